FILE: rtl/core/wsor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall segment occupancy rasterizer package
// Shared constants, request and register codes, controller states, and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package wsor_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_PIXEL_BITS = 16;

	localparam int SCALE_W    = 24;
	localparam int SCALE_FRAC = 16;
	localparam int HALF_W     = 7;
	localparam int GRID_CFG_W = 9;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int RC_W       = 8;
	localparam int VALUE_W    = 7;

	localparam logic [VALUE_W-1:0] WALL_VALUE = 7'd100;
	localparam logic [VALUE_W-1:0] FREE_VALUE = 7'd0;

	localparam logic [1:0] REQ_DRAW  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_THICK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd3;

	// coordinate slots: start column, start row, end column, end row
	localparam logic [1:0] SCALE_LAST = 2'd3;

	typedef struct packed {
		logic [SCALE_W-1:0]    scale_q16;
		logic [HALF_W-1:0]     half_thick;
		logic [GRID_CFG_W-1:0] grid_width;
		logic [GRID_CFG_W-1:0] grid_height;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCALE,
		ST_DRAIN,
		ST_BOUND,
		ST_CLIP,
		ST_FILL,
		ST_RADDR,
		ST_RDATA
	} state_t;

	typedef struct packed {
		logic       load;
		logic       clr_init;
		logic       clr_wr;
		logic       scale_go;
		logic [1:0] scale_sel;
		logic       bound;
		logic       clip;
		logic       fill_wr;
		logic       rd_go;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic fill_empty;
		logic fill_last;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/core/wsor_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall segment occupancy rasterizer channels
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsor_req_if import wsor_pkg::*; #(
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   req_type;
	logic signed [PIXEL_BITS-1:0] start_x;
	logic signed [PIXEL_BITS-1:0] start_y;
	logic signed [PIXEL_BITS-1:0] end_x;
	logic signed [PIXEL_BITS-1:0] end_y;
	logic [RC_W-1:0]              read_row;
	logic [RC_W-1:0]              read_col;

	modport source (
		output valid, req_type, start_x, start_y, end_x, end_y, read_row, read_col,
		input  ready
	);
	modport sink (
		input  valid, req_type, start_x, start_y, end_x, end_y, read_row, read_col,
		output ready
	);
endinterface

interface wsor_rsp_if import wsor_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] cell_value;
	logic [RC_W-1:0]    out_row;
	logic [RC_W-1:0]    out_col;

	modport source (output valid, cell_value, out_row, out_col, input ready);
	modport sink (input valid, cell_value, out_row, out_col, output ready);
endinterface

interface wsor_cfg_if import wsor_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/wsor_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall segment occupancy rasterizer configuration registers
// Holds scale, wall half thickness and grid size; written by index.
// ----------------------------------------------------------------------------
module wsor_cfg_regs import wsor_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output logic                  wr_ready,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_q16   <= 24'd65536;
			cfg_q.half_thick  <= 7'd1;
			cfg_q.grid_width  <= 9'd256;
			cfg_q.grid_height <= 9'd256;
		end else if (wr_valid) begin
			case (wr_index)
				CFG_SCALE:       cfg_q.scale_q16   <= wr_data[SCALE_W-1:0];
				CFG_HALF_THICK:  cfg_q.half_thick  <= wr_data[HALF_W-1:0];
				CFG_GRID_WIDTH:  cfg_q.grid_width  <= wr_data[GRID_CFG_W-1:0];
				CFG_GRID_HEIGHT: cfg_q.grid_height <= wr_data[GRID_CFG_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/wsor_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall segment occupancy rasterizer controller
// Sequences clearing, coordinate scaling, bounding, row fill and reads.
// ----------------------------------------------------------------------------
module wsor_ctrl import wsor_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_type,
	output logic       req_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t     state_q;
	state_t     state_d;
	logic [1:0] scale_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			scale_cnt_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCALE) begin
				scale_cnt_q <= scale_cnt_q + 2'd1;
			end else begin
				scale_cnt_q <= 2'd0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					case (req_type)
						REQ_DRAW:  state_d = ST_SCALE;
						REQ_READ:  state_d = ST_RADDR;
						REQ_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCALE: begin
				if (scale_cnt_q == SCALE_LAST) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_BOUND;
			ST_BOUND: state_d = ST_CLIP;
			ST_CLIP:  state_d = ST_FILL;
			ST_FILL: begin
				if (sts.fill_empty || sts.fill_last) state_d = ST_IDLE;
			end
			ST_RADDR: state_d = ST_RDATA;
			ST_RDATA: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				req_ready    = 1'b1;
				cmd.load     = req_valid;
				cmd.clr_init = req_valid && (req_type == REQ_CLEAR);
			end
			ST_SCALE: begin
				cmd.scale_go  = 1'b1;
				cmd.scale_sel = scale_cnt_q;
			end
			ST_DRAIN: ;
			ST_BOUND: cmd.bound = 1'b1;
			ST_CLIP:  cmd.clip  = 1'b1;
			ST_FILL:  cmd.fill_wr = !sts.fill_empty;
			ST_RADDR: cmd.rd_go = 1'b1;
			ST_RDATA: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/wsor_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall segment occupancy rasterizer datapath
// Pixel to cell scaling, wall rectangle bounds and clipping, the row-wide
// occupancy memory with bit write mask, and the result register.
// ----------------------------------------------------------------------------
module wsor_datapath import wsor_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  cmd_t                         cmd,
	output sts_t                         sts,
	input  logic signed [PIXEL_BITS-1:0] start_x,
	input  logic signed [PIXEL_BITS-1:0] start_y,
	input  logic signed [PIXEL_BITS-1:0] end_x,
	input  logic signed [PIXEL_BITS-1:0] end_y,
	input  logic [RC_W-1:0]              read_row,
	input  logic [RC_W-1:0]              read_col,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [VALUE_W-1:0]           cell_value,
	output logic [RC_W-1:0]              out_row,
	output logic [RC_W-1:0]              out_col
);

	localparam int CW  = PIXEL_BITS + 10;
	localparam int PW  = PIXEL_BITS + SCALE_W;
	localparam int QW  = PW - SCALE_FRAC;
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int CIW = $clog2(MAX_WIDTH);
	localparam int RB  = $clog2(MAX_HEIGHT + 1);
	localparam int CB  = $clog2(MAX_WIDTH + 1);
	localparam logic signed [CW-1:0] MAXH_C = CW'(MAX_HEIGHT);
	localparam logic signed [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
	localparam logic signed [CW-1:0] ZERO_C = CW'(0);
	localparam logic signed [CW-1:0] ONE_C  = CW'(1);

	// captured item
	logic [PIXEL_BITS-1:0] coord_q [4];
	logic [RC_W-1:0]       rr_q;
	logic [RC_W-1:0]       rc_q;

	// scaling
	logic [PIXEL_BITS-1:0]  coord_sel;
	logic [PIXEL_BITS-1:0]  mag;
	logic [PW-1:0]          prod_s1;
	logic                   prod_neg_s1;
	logic [1:0]             prod_sel_s1;
	logic                   prod_vld_s1;
	logic signed [CW-1:0]   q_ext;
	logic signed [CW-1:0]   cell_q [4];

	// bounds
	logic [7:0]           thick8;
	logic signed [CW-1:0] thick_c;
	logic signed [CW-1:0] sc, sr, ec, er;
	logic                 vert, horz;
	logic signed [CW-1:0] rmin, rmax, cmin, cmax;
	logic signed [CW-1:0] bnd_r0_q, bnd_r1_q, bnd_c0_q, bnd_c1_q;
	logic                 bnd_ok_q;

	// clipping and fill
	logic signed [CW-1:0] h_eff, w_eff;
	logic signed [CW-1:0] rlo, rhi, clo, chi;
	logic                 fill_empty_q;
	logic [RB-1:0]        fill_row_q;
	logic [RB-1:0]        rhi_q;
	logic [CB-1:0]        clo_q, chi_q;
	logic [MAX_WIDTH-1:0] col_mask;

	// memory
	logic [MAX_WIDTH-1:0] occ_mem_q [MAX_HEIGHT];
	logic                 mem_we;
	logic [MAX_WIDTH-1:0] mem_mask;
	logic                 mem_wbit;
	logic [MAX_WIDTH-1:0] rd_word_s1;
	logic                 rd_hit_s1;
	logic [CIW-1:0]       rd_col_s1;
	logic signed [CW-1:0] rr_c, rc_c, rd_row_c, rd_col_c;
	logic                 rd_hit;

	// result register
	logic               out_valid_q;
	logic [VALUE_W-1:0] cell_value_q;
	logic [RC_W-1:0]    out_row_q;
	logic [RC_W-1:0]    out_col_q;

	// ---- scaling: |p| * scale >> 16, sign restored on the registered product ----
	assign coord_sel = coord_q[cmd.scale_sel];
	assign mag       = coord_sel[PIXEL_BITS-1] ? (~coord_sel + 1'b1) : coord_sel;
	assign q_ext     = $signed({{(CW-QW){1'b0}}, prod_s1[PW-1:SCALE_FRAC]});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			coord_q[0] <= start_x;
			coord_q[1] <= start_y;
			coord_q[2] <= end_x;
			coord_q[3] <= end_y;
			rr_q       <= read_row;
			rc_q       <= read_col;
		end
		if (cmd.scale_go) begin
			prod_s1     <= PW'(mag) * PW'(cfg.scale_q16);
			prod_neg_s1 <= coord_sel[PIXEL_BITS-1];
			prod_sel_s1 <= cmd.scale_sel;
		end
		if (prod_vld_s1) begin
			cell_q[prod_sel_s1] <= prod_neg_s1 ? (ZERO_C - q_ext) : q_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= cmd.scale_go;
		end
	end

	// ---- wall rectangle, half-open bounds ----
	assign thick8  = (cfg.half_thick == '0) ? 8'd2 : {1'b0, cfg.half_thick} << 1;
	assign thick_c = $signed({{(CW-8){1'b0}}, thick8});
	assign sc      = cell_q[0];
	assign sr      = cell_q[1];
	assign ec      = cell_q[2];
	assign er      = cell_q[3];
	assign vert    = (sc == ec);
	assign horz    = (sr == er);
	assign rmin    = (sr < er) ? sr : er;
	assign rmax    = (sr < er) ? er : sr;
	assign cmin    = (sc < ec) ? sc : ec;
	assign cmax    = (sc < ec) ? ec : sc;

	always_ff @(posedge clk) begin
		if (cmd.bound) begin
			bnd_ok_q <= vert || horz;
			bnd_r0_q <= vert ? rmin : sr;
			bnd_r1_q <= vert ? (rmax + thick_c) : (sr + thick_c);
			bnd_c0_q <= vert ? sc : cmin;
			bnd_c1_q <= vert ? (sc + thick_c) : (cmax + thick_c);
		end
	end

	// ---- clipping to the grid in use ----
	assign h_eff = ($signed({{(CW-GRID_CFG_W){1'b0}}, cfg.grid_height}) > MAXH_C) ?
		MAXH_C : $signed({{(CW-GRID_CFG_W){1'b0}}, cfg.grid_height});
	assign w_eff = ($signed({{(CW-GRID_CFG_W){1'b0}}, cfg.grid_width}) > MAXW_C) ?
		MAXW_C : $signed({{(CW-GRID_CFG_W){1'b0}}, cfg.grid_width});
	assign rlo   = (bnd_r0_q < ZERO_C) ? ZERO_C : bnd_r0_q;
	assign rhi   = (bnd_r1_q < h_eff) ? bnd_r1_q : h_eff;
	assign clo   = (bnd_c0_q < ZERO_C) ? ZERO_C : bnd_c0_q;
	assign chi   = (bnd_c1_q < w_eff) ? bnd_c1_q : w_eff;

	always_ff @(posedge clk) begin
		if (cmd.clip) begin
			fill_empty_q <= !bnd_ok_q || (rlo >= rhi) || (clo >= chi);
			rhi_q        <= rhi[RB-1:0];
			clo_q        <= clo[CB-1:0];
			chi_q        <= chi[CB-1:0];
		end
	end

	// row counter shared by fill and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_row_q <= '0;
		end else if (cmd.clr_init) begin
			fill_row_q <= '0;
		end else if (cmd.clip) begin
			fill_row_q <= rlo[RB-1:0];
		end else if (cmd.fill_wr || cmd.clr_wr) begin
			fill_row_q <= fill_row_q + 1'b1;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_WIDTH; i++) begin
			col_mask[i] = (CB'(i) >= clo_q) && (CB'(i) < chi_q);
		end
	end

	assign mem_we   = cmd.fill_wr || cmd.clr_wr;
	assign mem_mask = cmd.clr_wr ? '1 : col_mask;
	assign mem_wbit = !cmd.clr_wr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				if (mem_mask[i]) occ_mem_q[fill_row_q[RW-1:0]][i] <= mem_wbit;
			end
		end
	end

	// ---- read of the rotated grid ----
	assign rr_c     = $signed({{(CW-RC_W){1'b0}}, rr_q});
	assign rc_c     = $signed({{(CW-RC_W){1'b0}}, rc_q});
	assign rd_hit   = (rr_c < h_eff) && (rc_c < w_eff);
	assign rd_row_c = h_eff - ONE_C - rr_c;
	assign rd_col_c = w_eff - ONE_C - rc_c;

	always_ff @(posedge clk) begin
		if (cmd.rd_go) begin
			rd_word_s1 <= occ_mem_q[rd_row_c[RW-1:0]];
			rd_hit_s1  <= rd_hit;
			rd_col_s1  <= rd_col_c[CIW-1:0];
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_value_q <= (rd_hit_s1 && rd_word_s1[rd_col_s1]) ? WALL_VALUE : FREE_VALUE;
			out_row_q    <= rr_q;
			out_col_q    <= rc_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = cell_value_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;

	assign sts.clr_last   = (fill_row_q == RB'(MAX_HEIGHT - 1));
	assign sts.fill_empty = fill_empty_q;
	assign sts.fill_last  = ({1'b0, fill_row_q} + 1'b1) >= {1'b0, rhi_q};
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

FILE: rtl/core/wall_segment_occupancy_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall segment occupancy rasterizer
// Scales wall segments to grid cells, fills them into a one-bit occupancy
// grid, and reads cells of the grid rotated by 180 degrees.
// ----------------------------------------------------------------------------
// One word is handled at a time. A draw word steps through scaling of the four
// coordinates, bounding and clipping, then the grid memory writes one masked
// row per cycle for each grid row the clipped wall covers. A read word fetches
// the grid row, then loads the result register, and waits only if the previous
// result has not been taken. A clear word writes all MAX_HEIGHT rows, one row
// per cycle. Out of reset the block runs a clearing pass over all rows before it takes the first request;
// register writes are taken at any time, but should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module wall_segment_occupancy_rasterizer_unit import wsor_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input logic         clk,
	input logic         arst_n,
	wsor_req_if.sink    req,
	wsor_rsp_if.source  rsp,
	wsor_cfg_if.sink    cfg
);

	cfg_t cfg_regs;
	cmd_t cmd;
	sts_t sts;

	wsor_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.wr_ready (cfg.ready),
		.cfg      (cfg_regs)
	);

	wsor_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wsor_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_regs),
		.cmd        (cmd),
		.sts        (sts),
		.start_x    (req.start_x),
		.start_y    (req.start_y),
		.end_x      (req.end_x),
		.end_y      (req.end_y),
		.read_row   (req.read_row),
		.read_col   (req.read_col),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.cell_value (rsp.cell_value),
		.out_row    (rsp.out_row),
		.out_col    (rsp.out_col)
	);

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wall segment occupancy rasterizer testbench
// Sends draw, read, clear and unknown words to the block. Between phases it
// rewrites the four registers. Read results are checked against a fixed value
// where given, else against a local occupancy grid updated as words are taken.
// ----------------------------------------------------------------------------
module tb_top;
	import wsor_pkg::*;

	localparam int         GRID_W          = DEF_MAX_WIDTH;
	localparam int         GRID_H          = DEF_MAX_HEIGHT;
	localparam int         PIX_W           = DEF_PIXEL_BITS;
	localparam longint     PIX_MAX         = 2**(PIX_W-1) - 1;
	localparam longint     PIX_MIN         = -(2**(PIX_W-1));
	localparam logic [1:0] REQ_UNKNOWN     = 2'd3;
	localparam int         SETTLE_CYCLES   = GRID_H + 64;
	localparam int         HOLD_CYCLES     = 400;
	localparam longint     LIMIT_CYCLES    = 4000000;
	localparam int         NUM_PHASES      = 9;
	localparam int         WORDS_PER_PHASE = 190;
	localparam int         N_DIRECTED      = 22;

	typedef struct packed {
		logic [1:0]              kind;
		logic signed [PIX_W-1:0] sx;
		logic signed [PIX_W-1:0] sy;
		logic signed [PIX_W-1:0] ex;
		logic signed [PIX_W-1:0] ey;
		logic [RC_W-1:0]         row;
		logic [RC_W-1:0]         col;
		logic                    typed;
		logic [VALUE_W-1:0]      value;
	} req_word_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RC_W-1:0]    row;
		logic [RC_W-1:0]    col;
	} cell_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	wsor_req_if #(.PIXEL_BITS(PIX_W)) req_ch ();
	wsor_rsp_if rsp_ch ();
	wsor_cfg_if cfg_ch ();

	wall_segment_occupancy_rasterizer_unit #(
		.MAX_WIDTH(GRID_W),
		.MAX_HEIGHT(GRID_H),
		.PIXEL_BITS(PIX_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source),
		.cfg(cfg_ch.sink)
	);

	// local copy of the grid and registers
	bit [GRID_W-1:0]       occ_rows [GRID_H];
	logic [SCALE_W-1:0]    scale_q16;
	logic [HALF_W-1:0]     half_thick;
	logic [GRID_CFG_W-1:0] grid_width;
	logic [GRID_CFG_W-1:0] grid_height;

	cell_rsp_t cell_rsp_q [$];
	int        errors;
	longint    cycle_count;
	bit        hold_req;
	bit        burst_mode;
	int        read_burst;
	bit        last_valid;
	longint    last_rlo, last_rhi, last_clo, last_chi;

	req_word_t directed_words [N_DIRECTED] = '{
		'{REQ_READ, 0, 0, 0, 0, 8'd0, 8'd0, 1'b1, FREE_VALUE},
		'{REQ_READ, 0, 0, 0, 0, 8'd255, 8'd255, 1'b1, FREE_VALUE},
		'{REQ_DRAW, 10, 20, 10, 40, 8'd0, 8'd0, 1'b0, FREE_VALUE},
		'{REQ_READ, 0, 0, 0, 0, 8'd225, 8'd245, 1'b0, FREE_VALUE},
		'{REQ_DRAW, 60, 100, 5, 100, 8'd0, 8'd0, 1'b0, FREE_VALUE},
		'{REQ_READ, 0, 0, 0, 0, 8'd155, 8'd250, 1'b0, FREE_VALUE},
		'{REQ_DRAW, 200, 200, 200, 200, 8'd0, 8'd0, 1'b0, FREE_VALUE},
		'{REQ_READ, 0, 0, 0, 0, 8'd55, 8'd55, 1'b0, FREE_VALUE},
		'{REQ_DRAW, 0, 0, 30, 30, 8'd0, 8'd0, 1'b0, FREE_VALUE},
		'{REQ_READ, 0, 0, 0, 0, 8'd255, 8'd255, 1'b0, FREE_VALUE},
		'{REQ_DRAW, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 8'd0, 8'd0, 1'b0,
			FREE_VALUE},
		'{REQ_DRAW, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 8'd0, 8'd0, 1'b0,
			FREE_VALUE},
		'{REQ_DRAW, 16'sh8000, 0, 16'sh7FFF, 0, 8'd0, 8'd0, 1'b0, FREE_VALUE},
		'{REQ_READ, 0, 0, 0, 0, 8'd255, 8'd0, 1'b0, FREE_VALUE},
		'{REQ_DRAW, 255, 250, 255, 16'sh7FFF, 8'd0, 8'd0, 1'b0, FREE_VALUE},
		'{REQ_READ, 0, 0, 0, 0, 8'd0, 8'd0, 1'b0, FREE_VALUE},
		'{REQ_UNKNOWN, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 8'hFF, 8'hFF, 1'b0,
			FREE_VALUE},
		'{REQ_READ, 0, 0, 0, 0, 8'h80, 8'h7F, 1'b0, FREE_VALUE},
		'{REQ_CLEAR, 0, 0, 0, 0, 8'd0, 8'd0, 1'b0, FREE_VALUE},
		'{REQ_READ, 0, 0, 0, 0, 8'd255, 8'd0, 1'b1, FREE_VALUE},
		'{REQ_READ, 0, 0, 0, 0, 8'd0, 8'd0, 1'b1, FREE_VALUE},
		'{REQ_READ, 0, 0, 0, 0, 8'd225, 8'd245, 1'b1, FREE_VALUE}
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("wall_segment_occupancy_rasterizer_unit test failed");
			$finish;
		end
	end

	function automatic int eff_w();
		return (grid_width > GRID_W) ? GRID_W : int'(grid_width);
	endfunction

	function automatic int eff_h();
		return (grid_height > GRID_H) ? GRID_H : int'(grid_height);
	endfunction

	// truncation toward zero on the magnitude
	function automatic longint scale_to_cell(input logic signed [PIX_W-1:0] pix);
		longint p, mag, q;
		p   = pix;
		mag = (p < 0) ? -p : p;
		q   = (mag * longint'(scale_q16)) >>> SCALE_FRAC;
		return (p < 0) ? -q : q;
	endfunction

	function automatic void fill_rect(input longint r0, r1, c0, c1);
		longint rlo, rhi, clo, chi, r, c;
		rlo = (r0 < 0) ? 0 : r0;
		rhi = (r1 < eff_h()) ? r1 : eff_h();
		clo = (c0 < 0) ? 0 : c0;
		chi = (c1 < eff_w()) ? c1 : eff_w();
		for (r = rlo; r < rhi; r++)
			for (c = clo; c < chi; c++)
				occ_rows[r][c] = 1'b1;
		if (rlo < rhi && clo < chi) begin
			last_valid = 1'b1;
			last_rlo   = rlo;
			last_rhi   = rhi;
			last_clo   = clo;
			last_chi   = chi;
		end
	endfunction

	function automatic void rasterize_wall(input req_word_t w);
		longint sc, sr, ec, er, thick;
		sc    = scale_to_cell(w.sx);
		sr    = scale_to_cell(w.sy);
		ec    = scale_to_cell(w.ex);
		er    = scale_to_cell(w.ey);
		thick = (half_thick == '0) ? 2 : 2 * longint'(half_thick);
		// equal columns win, so a point segment is a vertical wall
		if (sc == ec)
			fill_rect((sr < er) ? sr : er, ((sr < er) ? er : sr) + thick, sc, sc + thick);
		else if (sr == er)
			fill_rect(sr, sr + thick, (sc < ec) ? sc : ec, ((sc < ec) ? ec : sc) + thick);
	endfunction

	function automatic logic [VALUE_W-1:0] occupancy_at(input logic [RC_W-1:0] row, col);
		int h, w;
		h = eff_h();
		w = eff_w();
		if (int'(row) < h && int'(col) < w) begin
			if (occ_rows[h - 1 - int'(row)][w - 1 - int'(col)])
				return WALL_VALUE;
		end
		return FREE_VALUE;
	endfunction

	function automatic void predict_word(input req_word_t w);
		cell_rsp_t r;
		case (w.kind)
			REQ_DRAW: rasterize_wall(w);
			REQ_READ: begin
				r.value = w.typed ? w.value : occupancy_at(w.row, w.col);
				r.row   = w.row;
				r.col   = w.col;
				cell_rsp_q = {cell_rsp_q, r};
			end
			REQ_CLEAR: begin
				foreach (occ_rows[i])
					occ_rows[i] = '0;
				last_valid = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (burst_mode || roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// pixel that lands near the grid at the current scale, or any pixel
	function automatic logic signed [PIX_W-1:0] pick_pixel();
		longint grid_pos, pix;
		if (scale_q16 == '0 || $urandom_range(0, 9) == 0)
			return PIX_W'($urandom);
		grid_pos = longint'($urandom_range(0, GRID_H + 32)) - 16;
		pix      = (grid_pos <<< SCALE_FRAC) / longint'(scale_q16) + $urandom_range(0, 2);
		if (pix > PIX_MAX)
			pix = PIX_MAX;
		if (pix < PIX_MIN)
			pix = PIX_MIN;
		return pix[PIX_W-1:0];
	endfunction

	function automatic req_word_t random_word();
		req_word_t w;
		int roll;
		w.kind  = REQ_DRAW;
		w.sx    = pick_pixel();
		w.sy    = pick_pixel();
		w.ex    = pick_pixel();
		w.ey    = pick_pixel();
		w.row   = RC_W'($urandom);
		w.col   = RC_W'($urandom);
		w.typed = 1'b0;
		w.value = FREE_VALUE;
		roll    = $urandom_range(0, 99);
		if (read_burst > 0) begin
			read_burst--;
			roll = 70;
		end
		if (roll < 25) begin
			w.ex = ($urandom_range(0, 3) == 0) ? PIX_W'(w.sx + 1) : w.sx;
		end else if (roll < 48) begin
			w.ey = ($urandom_range(0, 3) == 0) ? PIX_W'(w.sy + 1) : w.sy;
		end else if (roll < 55) begin
			w.kind = REQ_DRAW;
		end else if (roll < 92) begin
			w.kind = REQ_READ;
			// half the reads land inside the last filled wall
			if (last_valid && $urandom_range(0, 1) == 1) begin
				w.row = RC_W'(eff_h() - 1 - $urandom_range(int'(last_rlo), int'(last_rhi) - 1));
				w.col = RC_W'(eff_w() - 1 - $urandom_range(int'(last_clo), int'(last_chi) - 1));
			end
		end else if (roll < 96) begin
			w.kind = REQ_CLEAR;
		end else begin
			w.kind = REQ_UNKNOWN;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	task automatic send_word(input req_word_t w);
		repeat (pick_gap()) @(negedge clk);
		req_ch.req_type = w.kind;
		req_ch.start_x  = w.sx;
		req_ch.start_y  = w.sy;
		req_ch.end_x    = w.ex;
		req_ch.end_y    = w.ey;
		req_ch.read_row = w.row;
		req_ch.read_col = w.col;
		req_ch.valid    = 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_word(w);
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.index = idx;
		cfg_ch.data  = data;
		cfg_ch.valid = 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			CFG_SCALE:       scale_q16   = data[SCALE_W-1:0];
			CFG_HALF_THICK:  half_thick  = data[HALF_W-1:0];
			CFG_GRID_WIDTH:  grid_width  = data[GRID_CFG_W-1:0];
			CFG_GRID_HEIGHT: grid_height = data[GRID_CFG_W-1:0];
			default: ;
		endcase
		last_valid = 1'b0;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// draws and clears give no result, so allow the longest one to finish
	task automatic settle();
		while (cell_rsp_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk) begin
		cell_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (cell_rsp_q.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: value %0d row %0d col %0d",
					rsp_ch.cell_value, rsp_ch.out_row, rsp_ch.out_col));
			end else begin
				want = cell_rsp_q.pop_front();
				if (rsp_ch.cell_value !== want.value)
					report_mismatch($sformatf("cell_value at (%0d,%0d): got %0d, expected %0d",
						want.row, want.col, rsp_ch.cell_value, want.value));
				if (rsp_ch.out_row !== want.row)
					report_mismatch($sformatf("out_row: got %0d, expected %0d",
						rsp_ch.out_row, want.row));
				if (rsp_ch.out_col !== want.col)
					report_mismatch($sformatf("out_col: got %0d, expected %0d",
						rsp_ch.out_col, want.col));
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		rsp_ch.ready = 1'b0;
		stall_left   = 0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = 1'b1;
				if (!burst_mode && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		int p;
		logic [SCALE_W-1:0]    s;
		logic [HALF_W-1:0]     hw;
		logic [GRID_CFG_W-1:0] gw, gh;
		logic [CFG_DATA_W-1:0] junk;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_DRAW;
		req_ch.start_x  = '0;
		req_ch.start_y  = '0;
		req_ch.end_x    = '0;
		req_ch.end_y    = '0;
		req_ch.read_row = '0;
		req_ch.read_col = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = CFG_SCALE;
		cfg_ch.data     = '0;
		foreach (occ_rows[i])
			occ_rows[i] = '0;
		scale_q16   = 24'd65536;
		half_thick  = 7'd1;
		grid_width  = 9'd256;
		grid_height = 9'd256;
		errors      = 0;
		cycle_count = 0;
		hold_req    = 1'b0;
		burst_mode  = 1'b0;
		read_burst  = 0;
		last_valid  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_words[i])
			send_word(directed_words[i]);

		for (p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: begin s = 24'd65536;    hw = 7'd1;   gw = 9'd256; gh = 9'd256; end
				1: begin s = 24'd1;        hw = 7'd64;  gw = 9'd256; gh = 9'd256; end
				2: begin s = 24'hFFFFFF;   hw = 7'd0;   gw = 9'd300; gh = 9'd511; end
				3: begin s = 24'd0;        hw = 7'd127; gw = 9'd256; gh = 9'd256; end
				4: begin s = 24'd32768;    hw = 7'd2;   gw = 9'd17;  gh = 9'd1;   end
				5: begin s = 24'd98304;    hw = 7'd3;   gw = 9'd1;   gh = 9'd0;   end
				6: begin s = 24'd65536;    hw = 7'd1;   gw = 9'd0;   gh = 9'd256; end
				default: begin
					s  = SCALE_W'($urandom_range(16384, 262144));
					hw = HALF_W'($urandom_range(0, 6));
					gw = GRID_CFG_W'($urandom_range(1, 511));
					gh = GRID_CFG_W'($urandom_range(1, 511));
				end
			endcase
			// unused upper data bits carry noise in the later phases
			junk = (p >= 7) ? CFG_DATA_W'($urandom) : '0;
			write_reg(CFG_SCALE, s);
			write_reg(CFG_HALF_THICK, CFG_DATA_W'(hw) | (junk << HALF_W));
			write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(gw) | (junk << GRID_CFG_W));
			write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(gh) | (junk << GRID_CFG_W));
			burst_mode = (p == 3 || p == 7);
			if (p == 0) begin
				// reads pile up behind a held result channel
				hold_req   = 1'b1;
				read_burst = 40;
			end
			repeat (WORDS_PER_PHASE) send_word(random_word());
		end

		settle();
		if (errors == 0)
			$display("wall_segment_occupancy_rasterizer_unit test passed");
		else
			$display("wall_segment_occupancy_rasterizer_unit test failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/wsor_pkg.sv
rtl/core/wsor_if.sv
rtl/core/wsor_cfg_regs.sv
rtl/core/wsor_ctrl.sv
rtl/core/wsor_datapath.sv
rtl/core/wall_segment_occupancy_rasterizer_unit.sv
test/tb_top.sv
